>>> rtl/core/tke_pkg.sv
// shared types and constants for the top-k exposure tracker
// no dependencies
package tke_pkg;

  localparam int unsigned TableSlotsDef = 8;
  localparam int unsigned TimeW         = 16;
  localparam int unsigned IdW           = 16;
  localparam int unsigned SlotW         = 3;
  localparam int unsigned CfgIdxW       = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUseBle    = 2'd0,
    CfgUseWindow = 2'd1,
    CfgUseUwb    = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CmdOffer  = 1'b0,
    CmdFinish = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StOffer,
    StScan,
    StScanEnd,
    StRdReq,
    StRdWait
  } state_e;

  typedef struct packed {
    logic             command;
    logic [IdW-1:0]   encounter_id;
    logic [TimeW-1:0] ble_first;
    logic [TimeW-1:0] ble_last;
    logic [TimeW-1:0] window_first;
    logic [TimeW-1:0] window_last;
    logic [TimeW-1:0] uwb_first;
    logic [TimeW-1:0] uwb_last;
  } tke_in_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   held_id;
    logic [TimeW-1:0] exposure;
    logic             valid_res;
    logic             final_res;
  } tke_out_t;

  typedef struct packed {
    logic use_ble;
    logic use_ble_window;
    logic use_uwb;
  } tke_cfg_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] exposure;
  } tke_entry_t;

endpackage

>>> rtl/core/tke_exposure.sv
// exposure of one offered word: largest enabled last minus first, modulo 2^16
// depends on tke_pkg
module tke_exposure (
  input  tke_pkg::tke_in_t          word_i,
  input  tke_pkg::tke_cfg_t         cfg_i,
  output logic [tke_pkg::TimeW-1:0] exposure_o
);
  import tke_pkg::*;

  logic [TimeW-1:0] span_ble;
  logic [TimeW-1:0] span_window;
  logic [TimeW-1:0] span_uwb;
  logic [TimeW-1:0] best_a;

  assign span_ble    = cfg_i.use_ble ? TimeW'(word_i.ble_last - word_i.ble_first) : '0;
  assign span_window = cfg_i.use_ble_window ?
                       TimeW'(word_i.window_last - word_i.window_first) : '0;
  assign span_uwb    = cfg_i.use_uwb ? TimeW'(word_i.uwb_last - word_i.uwb_first) : '0;

  assign best_a     = (span_window > span_ble) ? span_window : span_ble;
  assign exposure_o = (span_uwb > best_a) ? span_uwb : best_a;

endmodule

>>> rtl/core/tke_mem.sv
// slot table memory: one write port, one read port, registered read data
// depends on tke_pkg
module tke_mem #(
  parameter  int unsigned Depth = tke_pkg::TableSlotsDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tke_pkg::tke_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tke_pkg::tke_entry_t rdata_o
);
  import tke_pkg::*;

  tke_entry_t mem_q [Depth];
  tke_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/top_k_exposure_tracker.sv
// top-k exposure tracker: keeps the TableSlots longest encounters in a slot memory
// offer: fills the next free slot, is ignored when full and no longer than the minimum, or on
// replace overwrites the min slot and rescans (one slot per cycle from the single memory read port)
// finish: reads every slot through one read port, then clears the table
// reset: table empty, min slot 0, use_ble 1, use_ble_window 0, use_uwb 1
module top_k_exposure_tracker #(
  parameter int unsigned TableSlots = tke_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tke_pkg::tke_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tke_pkg::tke_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tke_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [0:0]                    cfg_wdata_i
);
  import tke_pkg::*;

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CntW = $clog2(TableSlots + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSlots - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TableSlots);

  state_e                  state_q, state_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic [IdxW-1:0]         pidx_q, pidx_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [IdxW-1:0]         min_slot_q, min_slot_d;
  logic [TimeW-1:0]        min_exp_q, min_exp_d;
  logic [TableSlots-1:0]   vld_q, vld_d;
  tke_cfg_t                cfg_q;
  logic [IdW-1:0]          id_q;
  logic [TimeW-1:0]        exp_q;
  logic [TimeW-1:0]        exp_calc;
  logic                    out_valid_q, out_valid_d;
  tke_out_t                out_q;
  logic                    out_load;
  tke_out_t                out_word;
  logic                    in_fire;

  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  tke_entry_t              mem_wdata;
  logic                    mem_re;
  logic [IdxW-1:0]         mem_raddr;
  tke_entry_t              mem_rdata;

  logic [4:0]              slot_ext;
  logic                    rd_vld;

  tke_exposure u_exposure (
    .word_i     (in_data_i),
    .cfg_i      (cfg_q),
    .exposure_o (exp_calc)
  );

  tke_mem #(
    .Depth (TableSlots)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // readout word
  assign slot_ext = 5'(idx_q);
  assign rd_vld   = vld_q[idx_q];
  always_comb begin
    out_word.slot      = slot_ext[SlotW-1:0];
    out_word.held_id   = rd_vld ? mem_rdata.id : '0;
    out_word.exposure  = rd_vld ? mem_rdata.exposure : '0;
    out_word.valid_res = rd_vld && (mem_rdata.exposure != '0);
    out_word.final_res = (idx_q == LastIdx);
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    fill_d     = fill_q;
    min_slot_d = min_slot_q;
    min_exp_d  = min_exp_q;
    vld_d      = vld_q;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = min_slot_q;
    mem_wdata  = '{id: id_q, exposure: exp_q};
    mem_re     = 1'b0;
    mem_raddr  = idx_q;

    // rescan compare on the word read last cycle
    if (pend_q && (mem_rdata.exposure < min_exp_q)) begin
      min_slot_d = pidx_q;
      min_exp_d  = mem_rdata.exposure;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          idx_d   = '0;
          state_d = (in_data_i.command == CmdFinish) ? StRdReq : StOffer;
        end
      end
      StOffer: begin
        if (fill_q < FullCnt) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[IdxW-1:0];
          vld_d[fill_q[IdxW-1:0]] = 1'b1;
          fill_d    = CntW'(fill_q + 1'b1);
          if ((fill_q == '0) || (min_exp_q > exp_q)) begin
            min_slot_d = fill_q[IdxW-1:0];
            min_exp_d  = exp_q;
          end
          state_d = StIdle;
        end else if (exp_q > min_exp_q) begin
          mem_we    = 1'b1;
          mem_waddr = min_slot_q;
          min_exp_d = exp_q;
          idx_d     = '0;
          state_d   = StScan;
        end else begin
          state_d = StIdle;
        end
      end
      StScan: begin
        mem_re = 1'b1;
        pend_d = 1'b1;
        pidx_d = idx_q;
        if (idx_q == LastIdx) begin
          state_d = StScanEnd;
        end else begin
          idx_d = IdxW'(idx_q + 1'b1);
        end
      end
      StScanEnd: begin
        state_d = StIdle;
      end
      StRdReq: begin
        mem_re  = 1'b1;
        state_d = StRdWait;
      end
      StRdWait: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (idx_q == LastIdx) begin
            vld_d      = '0;
            fill_d     = '0;
            min_slot_d = '0;
            min_exp_d  = '0;
            state_d    = StIdle;
          end else begin
            idx_d   = IdxW'(idx_q + 1'b1);
            state_d = StRdReq;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      fill_q      <= '0;
      min_slot_q  <= '0;
      min_exp_q   <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      fill_q      <= fill_d;
      min_slot_q  <= min_slot_d;
      min_exp_q   <= min_exp_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{use_ble: 1'b1, use_ble_window: 1'b0, use_uwb: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgUseBle:    cfg_q.use_ble        <= cfg_wdata_i[0];
        CfgUseWindow: cfg_q.use_ble_window <= cfg_wdata_i[0];
        CfgUseUwb:    cfg_q.use_uwb        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q  <= in_data_i.encounter_id;
      exp_q <= exp_calc;
    end
    if (out_load) begin
      out_q <= out_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
